/* hw/rtl/msd_pkg.sv */
// Types, constants and the code table of the Morse stream decoder.
`default_nettype none

package msd_pkg;

	// Symbol codes
	localparam logic [1:0] SYM_DOT   = 2'd0;
	localparam logic [1:0] SYM_DASH  = 2'd1;
	localparam logic [1:0] SYM_SPACE = 2'd2;

	// Code length limits
	localparam logic [3:0] MAX_KEPT = 4'd9;
	localparam logic [3:0] LEN_SAT  = 4'd10;
	localparam logic [2:0] SPACE_MAX = 3'd7;

	// Characters emitted outside the table
	localparam logic [6:0] CHAR_NUL   = 7'h00;
	localparam logic [6:0] CHAR_SPACE = 7'h20;
	localparam logic [6:0] CHAR_S     = 7'h53;
	localparam logic [6:0] CHAR_O     = 7'h4F;

	typedef struct packed {
		logic [1:0] symbol;
		logic       message_end;
	} sym_item_t;

	typedef struct packed {
		logic [6:0] character;
		logic       run_last;
		logic       message_done;
	} chr_item_t;

	// Group of up to three characters caused by one input item
	typedef struct packed {
		logic [2:0][6:0] chars;
		logic [1:0]      count;
		logic            done;
	} grp_t;

	typedef struct packed {
		logic       sos;
		logic [6:0] ch;
	} lookup_t;

	// Map a code (length, symbols with the first one highest, dash 1) to its character
	function automatic lookup_t code_lookup(input logic [3:0] len, input logic [8:0] bits);
		lookup_t r;
		r.sos = 1'b0;
		r.ch  = CHAR_NUL;
		unique case ({len, bits})
			{4'd2, 9'b01}:        r.ch = 7'h41; // A
			{4'd4, 9'b1000}:      r.ch = 7'h42; // B
			{4'd4, 9'b1010}:      r.ch = 7'h43; // C
			{4'd3, 9'b100}:       r.ch = 7'h44; // D
			{4'd1, 9'b0}:         r.ch = 7'h45; // E
			{4'd4, 9'b0010}:      r.ch = 7'h46; // F
			{4'd3, 9'b110}:       r.ch = 7'h47; // G
			{4'd4, 9'b0000}:      r.ch = 7'h48; // H
			{4'd2, 9'b00}:        r.ch = 7'h49; // I
			{4'd4, 9'b0111}:      r.ch = 7'h4A; // J
			{4'd3, 9'b101}:       r.ch = 7'h4B; // K
			{4'd4, 9'b0100}:      r.ch = 7'h4C; // L
			{4'd2, 9'b11}:        r.ch = 7'h4D; // M
			{4'd2, 9'b10}:        r.ch = 7'h4E; // N
			{4'd3, 9'b111}:       r.ch = 7'h4F; // O
			{4'd4, 9'b0110}:      r.ch = 7'h50; // P
			{4'd4, 9'b1101}:      r.ch = 7'h51; // Q
			{4'd3, 9'b010}:       r.ch = 7'h52; // R
			{4'd3, 9'b000}:       r.ch = 7'h53; // S
			{4'd1, 9'b1}:         r.ch = 7'h54; // T
			{4'd3, 9'b001}:       r.ch = 7'h55; // U
			{4'd4, 9'b0001}:      r.ch = 7'h56; // V
			{4'd3, 9'b011}:       r.ch = 7'h57; // W
			{4'd4, 9'b1001}:      r.ch = 7'h58; // X
			{4'd4, 9'b1011}:      r.ch = 7'h59; // Y
			{4'd4, 9'b1100}:      r.ch = 7'h5A; // Z
			{4'd5, 9'b11111}:     r.ch = 7'h30; // 0
			{4'd5, 9'b01111}:     r.ch = 7'h31; // 1
			{4'd5, 9'b00111}:     r.ch = 7'h32; // 2
			{4'd5, 9'b00011}:     r.ch = 7'h33; // 3
			{4'd5, 9'b00001}:     r.ch = 7'h34; // 4
			{4'd5, 9'b00000}:     r.ch = 7'h35; // 5
			{4'd5, 9'b10000}:     r.ch = 7'h36; // 6
			{4'd5, 9'b11000}:     r.ch = 7'h37; // 7
			{4'd5, 9'b11100}:     r.ch = 7'h38; // 8
			{4'd5, 9'b11110}:     r.ch = 7'h39; // 9
			{4'd6, 9'b010101}:    r.ch = 7'h2E; // period
			{4'd6, 9'b110011}:    r.ch = 7'h2C; // comma
			{4'd6, 9'b001100}:    r.ch = 7'h3F; // question mark
			{4'd6, 9'b011110}:    r.ch = 7'h27; // apostrophe
			{4'd6, 9'b101011}:    r.ch = 7'h21; // exclamation mark
			{4'd5, 9'b10010}:     r.ch = 7'h2F; // slash
			{4'd5, 9'b10110}:     r.ch = 7'h28; // open paren
			{4'd6, 9'b101101}:    r.ch = 7'h29; // close paren
			{4'd5, 9'b01000}:     r.ch = 7'h26; // ampersand
			{4'd6, 9'b111000}:    r.ch = 7'h3A; // colon
			{4'd6, 9'b101010}:    r.ch = 7'h3B; // semicolon
			{4'd5, 9'b10001}:     r.ch = 7'h3D; // equals
			{4'd5, 9'b01010}:     r.ch = 7'h2B; // plus
			{4'd6, 9'b100001}:    r.ch = 7'h2D; // hyphen
			{4'd6, 9'b001101}:    r.ch = 7'h5F; // underscore
			{4'd6, 9'b010010}:    r.ch = 7'h22; // quote
			{4'd7, 9'b0001001}:   r.ch = 7'h24; // dollar
			{4'd6, 9'b011010}:    r.ch = 7'h40; // at sign
			{4'd9, 9'b000111000}: begin // SOS prosign
				r.sos = 1'b1;
				r.ch  = CHAR_S;
			end
			default:              r.ch = CHAR_NUL;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/msd_decode.sv */
// Input register, code state and per-item decode of the Morse stream decoder.
`default_nettype none

module msd_decode (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             sym_valid,
	output logic                  sym_stall,
	input  wire msd_pkg::sym_item_t sym_item,
	input  wire logic [2:0]       word_gap,
	input  wire logic             grp_free,
	output logic                  grp_load,
	output msd_pkg::grp_t         grp
);

	logic                valid_s1;
	msd_pkg::sym_item_t  item_s1;

	logic [8:0] code_bits_q;
	logic [3:0] code_length_q;
	logic [2:0] space_count_q;
	logic       seen_code_q;

	logic [8:0] nxt_bits;
	logic [3:0] nxt_len;
	logic [2:0] nxt_space;
	logic       nxt_seen;

	logic            is_mark;
	logic            is_space;
	logic            emit_space;
	logic            code_emit;
	logic [3:0]      key_len;
	logic [8:0]      key_bits;
	msd_pkg::lookup_t hit;
	logic [1:0]      count;
	logic            advance;
	logic            accept;

	assign is_mark  = (item_s1.symbol == msd_pkg::SYM_DOT) ||
	                  (item_s1.symbol == msd_pkg::SYM_DASH);
	assign is_space = (item_s1.symbol == msd_pkg::SYM_SPACE);

	assign emit_space = is_mark && (code_length_q == 4'd0) && seen_code_q &&
	                    (word_gap != 3'd0) && (space_count_q == word_gap);

	// State after the symbol, before the end of message is applied
	always_comb begin
		nxt_bits  = code_bits_q;
		nxt_len   = code_length_q;
		nxt_space = space_count_q;
		nxt_seen  = seen_code_q;
		if (is_mark) begin
			if (code_length_q == 4'd0) begin
				nxt_seen  = 1'b1;
				nxt_space = 3'd0;
			end
			if (code_length_q < msd_pkg::MAX_KEPT) begin
				nxt_bits = {code_bits_q[7:0], item_s1.symbol[0]};
			end
			if (code_length_q < msd_pkg::LEN_SAT) begin
				nxt_len = 4'(code_length_q + 4'd1);
			end
		end else if (is_space) begin
			if (code_length_q != 4'd0) begin
				nxt_bits  = 9'd0;
				nxt_len   = 4'd0;
				nxt_space = 3'd1;
			end else if (seen_code_q) begin
				if (space_count_q == msd_pkg::SPACE_MAX) begin
					nxt_space = 3'd0;
				end else if (space_count_q != 3'd0) begin
					nxt_space = 3'(space_count_q + 3'd1);
				end
			end
		end
	end

	// A space closes the stored code; the end mark closes the updated one
	assign key_len   = is_space ? code_length_q : nxt_len;
	assign key_bits  = is_space ? code_bits_q : nxt_bits;
	assign code_emit = (is_space && (code_length_q != 4'd0)) ||
	                   (item_s1.message_end && (nxt_len != 4'd0));
	assign hit       = msd_pkg::code_lookup(key_len, key_bits);

	always_comb begin
		count = {1'b0, emit_space};
		if (code_emit) begin
			count = hit.sos ? 2'd3 : 2'(count + 2'd1);
		end
		if (item_s1.message_end && (count == 2'd0)) begin
			count = 2'd1;
		end
	end

	always_comb begin
		grp.count    = count;
		grp.done     = item_s1.message_end;
		grp.chars[0] = emit_space ? msd_pkg::CHAR_SPACE :
		               (code_emit ? hit.ch : msd_pkg::CHAR_NUL);
		grp.chars[1] = emit_space ? hit.ch : msd_pkg::CHAR_O;
		grp.chars[2] = msd_pkg::CHAR_S;
	end

	// Items that emit nothing retire regardless of the output side
	assign advance   = valid_s1 && ((count == 2'd0) || grp_free);
	assign grp_load  = advance && (count != 2'd0);
	assign sym_stall = valid_s1 && !advance;
	assign accept    = sym_valid && !sym_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			code_bits_q   <= 9'd0;
			code_length_q <= 4'd0;
			space_count_q <= 3'd0;
			seen_code_q   <= 1'b0;
		end else begin
			valid_s1 <= accept || sym_stall;
			if (advance) begin
				if (item_s1.message_end) begin
					code_bits_q   <= 9'd0;
					code_length_q <= 4'd0;
					space_count_q <= 3'd0;
					seen_code_q   <= 1'b0;
				end else begin
					code_bits_q   <= nxt_bits;
					code_length_q <= nxt_len;
					space_count_q <= nxt_space;
					seen_code_q   <= nxt_seen;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= sym_item;
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/msd_drain.sv */
// Result register that hands out a group of characters one item per cycle while chr_stall is low.
`default_nettype none

module msd_drain (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          grp_load,
	input  wire msd_pkg::grp_t grp,
	output logic               grp_free,
	output logic               chr_valid,
	input  wire logic          chr_stall,
	output msd_pkg::chr_item_t chr_item
);

	logic          valid_q;
	logic [1:0]    idx_q;
	msd_pkg::grp_t grp_q;
	logic          last;
	logic          fire;

	assign last     = (idx_q == 2'(grp_q.count - 2'd1));
	assign fire     = valid_q && !chr_stall;
	assign grp_free = !valid_q || (fire && last);

	assign chr_valid = valid_q;

	always_comb begin
		case (idx_q)
			2'd0:    chr_item.character = grp_q.chars[0];
			2'd1:    chr_item.character = grp_q.chars[1];
			default: chr_item.character = grp_q.chars[2];
		endcase
		chr_item.run_last     = last;
		chr_item.message_done = last && grp_q.done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 2'd0;
		end else if (grp_load) begin
			valid_q <= 1'b1;
			idx_q   <= 2'd0;
		end else if (fire) begin
			if (last) begin
				valid_q <= 1'b0;
			end else begin
				idx_q <= 2'(idx_q + 2'd1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (grp_load) begin
			grp_q <= grp;
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/morse_stream_decoder_unit.sv */
// Top level of the Morse stream decoder: configuration register and the two stages.
//
//  channel  direction  handshake              payload
//  sym      in         sym_valid / sym_stall  sym_item   (symbol, message_end)
//  chr      out        chr_valid / chr_stall  chr_item   (character, run_last, message_done)
//  cfg      in         cfg_valid / cfg_ready  cfg_data   (word_gap)
//
// An accepted item sits in the input register, where the code state is
// updated and its characters (up to three) are looked up; the group then moves to the
// result register and leaves one item per cycle while chr_stall is low.
// An item yields up to three results; items with none retire without the result register.
// The result register is the limit: a stalled output holds it and then the input stage.
// Reset clears the code state, the stage valids and sets word_gap to 3.
`default_nettype none

module morse_stream_decoder_unit (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                sym_valid,
	output logic                     sym_stall,
	input  wire msd_pkg::sym_item_t  sym_item,
	output logic                     chr_valid,
	input  wire logic                chr_stall,
	output msd_pkg::chr_item_t       chr_item,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [2:0]          cfg_data
);

	logic [2:0]    word_gap_q;
	logic          grp_free;
	logic          grp_load;
	msd_pkg::grp_t grp;

	// Config writes must arrive only while idle; the user is bound, the block does not enforce it, so always take them
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_gap_q <= 3'd3;
		end else if (cfg_valid && cfg_ready) begin
			word_gap_q <= cfg_data;
		end
	end

	// Decode stage: hold the item, advance the code state, build the group
	msd_decode u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.sym_valid (sym_valid),
		.sym_stall (sym_stall),
		.sym_item  (sym_item),
		.word_gap  (word_gap_q),
		.grp_free  (grp_free),
		.grp_load  (grp_load),
		.grp       (grp)
	);

	// Result stage: drop the group out one character per cycle while chr_stall is low
	msd_drain u_drain (
		.clk       (clk),
		.arst_n    (arst_n),
		.grp_load  (grp_load),
		.grp       (grp),
		.grp_free  (grp_free),
		.chr_valid (chr_valid),
		.chr_stall (chr_stall),
		.chr_item  (chr_item)
	);

	// The end of a message always closes the item's run
	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		chr_valid && chr_item.message_done |-> chr_item.run_last)
		else $error("message_done without run_last");

	// With an empty result register the input side never stalls
	a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!chr_valid |-> !sym_stall)
		else $error("input stalled while output empty");

	// A run that is not finished keeps the output valid
	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		chr_valid && !chr_stall && !chr_item.run_last |=> chr_valid)
		else $error("result run broken");

endmodule

`default_nettype wire
